FILE: sv/bped_pkg.sv
// Shared types and constants of the button press event detector.
package bped_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned EventW = 3;
  localparam int unsigned CfgIdxW = 1;

  typedef logic [EventW-1:0] event_t;

  localparam event_t EV_NONE      = 3'd0;
  localparam event_t EV_TOGGLE    = 3'd1;
  localparam event_t EV_UP        = 3'd2;
  localparam event_t EV_UP_LONG   = 3'd3;
  localparam event_t EV_DOWN      = 3'd4;
  localparam event_t EV_DOWN_LONG = 3'd5;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS = 1'd1;

  localparam logic [CfgW-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CfgW-1:0] LONG_PRESS_RST = 16'd300;

  // Button tracking state carried from one sample to the next.
  typedef struct packed {
    event_t           pending_event;
    logic             screen_last;
    logic [TimeW-1:0] screen_stamp;
    logic             up_last;
    logic [TimeW-1:0] up_start;
    logic             up_long_done;
    logic             down_last;
    logic [TimeW-1:0] down_start;
    logic             down_long_done;
  } bped_state_t;

  // One input beat.
  typedef struct packed {
    logic             kind;
    logic [TimeW-1:0] time_ms;
    logic             screen_pressed;
    logic             page_up_pressed;
    logic             page_down_pressed;
  } bped_item_t;

  // One result beat.
  typedef struct packed {
    event_t event_res;
    logic   event_pending;
  } bped_result_t;

endpackage

FILE: sv/bped_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface bped_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] time_ms;
  logic        screen_pressed;
  logic        page_up_pressed;
  logic        page_down_pressed;

  modport source (output valid, kind, time_ms, screen_pressed, page_up_pressed,
                  page_down_pressed, input ready);
  modport sink   (input valid, kind, time_ms, screen_pressed, page_up_pressed,
                  page_down_pressed, output ready);
endinterface

interface bped_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic       event_pending;

  modport source (output valid, event_res, event_pending, input ready);
  modport sink   (input valid, event_res, event_pending, output ready);
endinterface

FILE: sv/bped_step.sv
// Combinational next-state and result logic for one beat.
module bped_step (
  input  bped_pkg::bped_state_t             cur,
  input  bped_pkg::bped_item_t              item,
  input  logic [bped_pkg::CfgW-1:0]         debounce_ms,
  input  logic [bped_pkg::CfgW-1:0]         long_press_ms,
  output bped_pkg::bped_state_t             nxt,
  output bped_pkg::bped_result_t            res
);
  import bped_pkg::*;

  logic [TimeW-1:0] screen_el;
  logic [TimeW-1:0] up_el;
  logic [TimeW-1:0] down_el;
  logic             screen_ok;
  logic             up_long;
  logic             down_long;

  // Elapsed times wrap modulo 2^32.
  assign screen_el = item.time_ms - cur.screen_stamp;
  assign up_el     = item.time_ms - cur.up_start;
  assign down_el   = item.time_ms - cur.down_start;
  assign screen_ok = screen_el >= {{(TimeW-CfgW){1'b0}}, debounce_ms};
  assign up_long   = up_el >= {{(TimeW-CfgW){1'b0}}, long_press_ms};
  assign down_long = down_el >= {{(TimeW-CfgW){1'b0}}, long_press_ms};

  always_comb begin
    logic   fired;
    event_t taken;
    fired = 1'b0;
    taken = EV_NONE;
    nxt   = cur;
    if (item.kind) begin
      taken = cur.pending_event;
      nxt.pending_event = EV_NONE;
    end else if (cur.pending_event == EV_NONE) begin
      // Toggle button: a press edge counts only outside the debounce window.
      if (item.screen_pressed && !cur.screen_last) begin
        if (screen_ok) begin
          nxt.screen_last   = 1'b1;
          nxt.screen_stamp  = item.time_ms;
          nxt.pending_event = EV_TOGGLE;
          fired = 1'b1;
        end
      end else begin
        nxt.screen_last = item.screen_pressed;
        if (!item.screen_pressed) begin
          nxt.screen_stamp = item.time_ms;
        end
      end

      // Page up.
      if (!fired) begin
        if (item.page_up_pressed && !cur.up_last) begin
          nxt.up_start     = item.time_ms;
          nxt.up_long_done = 1'b0;
        end else if (item.page_up_pressed && cur.up_last) begin
          if (!cur.up_long_done && up_long) begin
            nxt.up_long_done  = 1'b1;
            nxt.pending_event = EV_UP_LONG;
            fired = 1'b1;
          end
        end else if (!item.page_up_pressed && cur.up_last) begin
          if (!cur.up_long_done) begin
            nxt.up_last       = 1'b0;
            nxt.pending_event = EV_UP;
            fired = 1'b1;
          end
        end
      end

      // Page down.
      if (!fired) begin
        if (item.page_down_pressed && !cur.down_last) begin
          nxt.down_start     = item.time_ms;
          nxt.down_long_done = 1'b0;
        end else if (item.page_down_pressed && cur.down_last) begin
          if (!cur.down_long_done && down_long) begin
            nxt.down_long_done = 1'b1;
            nxt.pending_event  = EV_DOWN_LONG;
            fired = 1'b1;
          end
        end else if (!item.page_down_pressed && cur.down_last) begin
          if (!cur.down_long_done) begin
            nxt.down_last     = 1'b0;
            nxt.pending_event = EV_DOWN;
            fired = 1'b1;
          end
        end
      end

      // Levels of both page buttons are recorded when nothing fired; a short event records only its own release.
      if (!fired) begin
        nxt.up_last   = item.page_up_pressed;
        nxt.down_last = item.page_down_pressed;
      end
    end
    res.event_res     = taken;
    res.event_pending = (nxt.pending_event != EV_NONE);
  end

endmodule

FILE: sv/button_press_event_detector_core.sv
// Top level of the button press event detector: registers, handshakes and config.
//
// The block takes one beat per clock cycle, back to back, while the output
// side is ready, and every beat gives exactly one result beat. A beat is
// first captured in an input register; in the cycle it leaves that
// register, the button state is updated and the result is written to the
// output register. A result beat is therefore offered from the output
// register after its input beat has left the input register, and it is
// taken when the output side is ready. The two registers let a new input
// beat be accepted while a finished result still waits at the output. A sample
// beat (kind 0) is ignored while an event is pending; a take beat (kind 1)
// returns the pending event code and clears it. The toggle button is
// debounced with debounce_ms; the page buttons give a long event after
// long_press_ms of holding, or a short event on release. Configuration
// writes through the cfg_ port take effect at once and must be done while
// the block is idle.
module button_press_event_detector_core (
  input  logic                          clk,
  input  logic                          rst_n,
  bped_in_if.sink                       in_bus,
  bped_out_if.source                    out_bus,
  input  logic                          cfg_we,
  input  logic [bped_pkg::CfgIdxW-1:0]  cfg_idx,
  input  logic [bped_pkg::CfgW-1:0]     cfg_data
);
  import bped_pkg::*;

  // Configuration registers.
  logic [CfgW-1:0] debounce_r;
  logic [CfgW-1:0] long_press_r;

  // Input register stage.
  logic        in_valid_r;
  bped_item_t  item_r;

  // Output register stage.
  logic         out_valid_r;
  bped_result_t res_r;

  // Button state.
  bped_state_t  state_r;
  bped_state_t  state_nxt;
  bped_result_t res_nxt;

  logic advance;

  // The input register moves on whenever the output register is free or
  // is being emptied in this cycle.
  assign advance      = !out_valid_r || out_bus.ready;
  assign in_bus.ready = !in_valid_r || advance;

  assign out_bus.valid         = out_valid_r;
  assign out_bus.event_res     = res_r.event_res;
  assign out_bus.event_pending = res_r.event_pending;

  bped_step u_step (
    .cur           (state_r),
    .item          (item_r),
    .debounce_ms   (debounce_r),
    .long_press_ms (long_press_r),
    .nxt           (state_nxt),
    .res           (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= DEBOUNCE_RST;
      long_press_r <= LONG_PRESS_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE:   debounce_r   <= cfg_data;
        CFG_LONG_PRESS: long_press_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_bus.ready) begin
        in_valid_r <= in_bus.valid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      item_r.kind              <= in_bus.kind;
      item_r.time_ms           <= in_bus.time_ms;
      item_r.screen_pressed    <= in_bus.screen_pressed;
      item_r.page_up_pressed   <= in_bus.page_up_pressed;
      item_r.page_down_pressed <= in_bus.page_down_pressed;
    end
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

endmodule

FILE: sim/button_press_event_detector_core_test.sv
// Self-checking testbench of the button press event detector core.

// Tracks the expected button state and the beats still due at the output.
class event_scoreboard;

  typedef enum int {BTN_UP = 0, BTN_DOWN = 1} page_btn_e;

  typedef struct packed {
    logic        last;
    logic [31:0] start;
    logic        long_done;
  } page_state_t;

  logic [15:0]            debounce_ms;
  logic [15:0]            long_press_ms;
  bped_pkg::event_t       pending;
  logic                   scr_last;
  logic [31:0]            scr_stamp;
  page_state_t            page[2];
  bped_pkg::bped_result_t expected_q[$];
  int                     errors;

  function new();
    debounce_ms   = bped_pkg::DEBOUNCE_RST;
    long_press_ms = bped_pkg::LONG_PRESS_RST;
    pending       = bped_pkg::EV_NONE;
    scr_last      = 1'b0;
    scr_stamp     = '0;
    page[BTN_UP]   = '0;
    page[BTN_DOWN] = '0;
    errors        = 0;
  endfunction

  function void set_reg(logic [bped_pkg::CfgIdxW-1:0] idx, logic [bped_pkg::CfgW-1:0] value);
    if (idx == bped_pkg::CFG_DEBOUNCE) begin
      debounce_ms = value;
    end else if (idx == bped_pkg::CFG_LONG_PRESS) begin
      long_press_ms = value;
    end
  endfunction

  // One page button: press edge arms the timer, holding may give the long
  // event once, a release without a long event gives the short one.
  function bped_pkg::event_t page_step(page_btn_e b, logic now, logic [31:0] t,
                                       bped_pkg::event_t ev_short,
                                       bped_pkg::event_t ev_long);
    logic [31:0] held;
    held = t - page[b].start;
    if (now && !page[b].last) begin
      page[b].start     = t;
      page[b].long_done = 1'b0;
    end else if (now && page[b].last) begin
      if (!page[b].long_done && held >= {16'd0, long_press_ms}) begin
        page[b].long_done = 1'b1;
        return ev_long;
      end
    end else if (!now && page[b].last) begin
      if (!page[b].long_done) begin
        page[b].last = 1'b0;
        return ev_short;
      end
    end
    return bped_pkg::EV_NONE;
  endfunction

  function void apply_sample(logic [31:0] t, logic scr, logic up, logic dn);
    logic [31:0]      since;
    bped_pkg::event_t ev;
    since = t - scr_stamp;
    if (pending != bped_pkg::EV_NONE) return;
    if (scr && !scr_last) begin
      if (since >= {16'd0, debounce_ms}) begin
        scr_last  = 1'b1;
        scr_stamp = t;
        pending   = bped_pkg::EV_TOGGLE;
        return;
      end
    end else begin
      scr_last = scr;
      if (!scr) scr_stamp = t;
    end
    ev = page_step(BTN_UP, up, t, bped_pkg::EV_UP, bped_pkg::EV_UP_LONG);
    if (ev != bped_pkg::EV_NONE) begin
      pending = ev;
      return;
    end
    ev = page_step(BTN_DOWN, dn, t, bped_pkg::EV_DOWN, bped_pkg::EV_DOWN_LONG);
    if (ev != bped_pkg::EV_NONE) begin
      pending = ev;
      return;
    end
    page[BTN_UP].last   = up;
    page[BTN_DOWN].last = dn;
  endfunction

  function void note_item(bped_pkg::bped_item_t it);
    bped_pkg::bped_result_t exp_res;
    bped_pkg::event_t       taken;
    taken = bped_pkg::EV_NONE;
    if (it.kind) begin
      taken   = pending;
      pending = bped_pkg::EV_NONE;
    end else begin
      apply_sample(it.time_ms, it.screen_pressed, it.page_up_pressed, it.page_down_pressed);
    end
    exp_res.event_res     = taken;
    exp_res.event_pending = (pending != bped_pkg::EV_NONE);
    expected_q.push_back(exp_res);
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task check_result(bped_pkg::bped_result_t got);
    bped_pkg::bped_result_t exp_res;
    if (expected_q.size() == 0) begin
      report($sformatf("result beat event_res=%0d event_pending=%0d with none expected",
                       got.event_res, got.event_pending));
    end else begin
      exp_res = expected_q.pop_front();
      if (got.event_res !== exp_res.event_res)
        report($sformatf("event_res got %0d expected %0d", got.event_res, exp_res.event_res));
      if (got.event_pending !== exp_res.event_pending)
        report($sformatf("event_pending got %0d expected %0d",
                         got.event_pending, exp_res.event_pending));
    end
  endtask

endclass

module button_press_event_detector_core_test;
  import bped_pkg::*;

  // A run that accepts nothing on either side for this many cycles is hung.
  localparam int QUIET_LIMIT = 5000;
  // Cycles allowed after the last result before the idle-only actions.
  localparam int SETTLE_CYCLES = 4;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int NUM_PHASES = 6;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_data;

  bped_in_if  in_ch();
  bped_out_if out_ch();

  event_scoreboard sb = new();

  // Percent of cycles in which the sender holds back and the receiver stalls.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  // Stimulus state: millisecond time stamp of the beats and the held levels.
  logic [31:0] now_ms;
  logic        lvl_scr;
  logic        lvl_up;
  logic        lvl_dn;

  int          quiet_cycles;
  logic        in_taken;
  logic        out_taken;
  bped_item_t   mon_item;
  bped_result_t mon_result;

  bped_item_t directed_q[$];

  button_press_event_detector_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_ch),
    .out_bus  (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  // The receiver stalls at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Every accepted input beat feeds the predictor, every accepted result beat
  // is checked against the oldest prediction. The same block watches for a
  // hang: too many cycles with no beat moving on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken  = in_ch.valid && in_ch.ready;
      out_taken = out_ch.valid && out_ch.ready;
      if (in_taken) begin
        mon_item.kind              = in_ch.kind;
        mon_item.time_ms           = in_ch.time_ms;
        mon_item.screen_pressed    = in_ch.screen_pressed;
        mon_item.page_up_pressed   = in_ch.page_up_pressed;
        mon_item.page_down_pressed = in_ch.page_down_pressed;
        sb.note_item(mon_item);
      end
      if (out_taken) begin
        mon_result.event_res     = out_ch.event_res;
        mon_result.event_pending = out_ch.event_pending;
        sb.check_result(mon_result);
      end
      if (in_taken || out_taken) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("button_press_event_detector_core_test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic bped_item_t make_item(logic kind, logic [31:0] t, logic scr,
                                           logic up, logic dn);
    bped_item_t it;
    it.kind              = kind;
    it.time_ms           = t;
    it.screen_pressed    = scr;
    it.page_up_pressed   = up;
    it.page_down_pressed = dn;
    return it;
  endfunction

  // Random beat. Time mostly advances in steps scaled to the larger of the
  // two thresholds, so debounce windows and long presses are crossed from
  // both sides; now and then it jumps anywhere, which also exercises the
  // wrap of the time subtraction. Levels are held and flip now and then so
  // that presses, holds and releases form real sequences; a few beats carry
  // fully random levels as noise.
  function automatic bped_item_t next_random_item();
    bped_item_t  it;
    int unsigned r;
    int unsigned span;
    span = ((sb.debounce_ms > sb.long_press_ms) ? sb.debounce_ms : sb.long_press_ms) + 2;
    r = $urandom_range(99);
    if (r < 10) begin
      // Same millisecond as the previous beat.
    end else if (r < 45) begin
      now_ms = now_ms + $urandom_range(span / 16 + 1);
    end else if (r < 85) begin
      now_ms = now_ms + $urandom_range(span / 4 + 1);
    end else if (r < 97) begin
      now_ms = now_ms + $urandom_range(span);
    end else begin
      now_ms = $urandom;
    end
    if ($urandom_range(99) < 10) begin
      lvl_scr = 1'($urandom_range(1));
      lvl_up  = 1'($urandom_range(1));
      lvl_dn  = 1'($urandom_range(1));
    end else begin
      if ($urandom_range(99) < 30) lvl_scr = !lvl_scr;
      if ($urandom_range(99) < 30) lvl_up  = !lvl_up;
      if ($urandom_range(99) < 30) lvl_dn  = !lvl_dn;
    end
    it = make_item($urandom_range(99) < 35, now_ms, lvl_scr, lvl_up, lvl_dn);
    // A take beat ignores time and levels, so they may be anything.
    if (it.kind && $urandom_range(1)) begin
      it.time_ms           = $urandom;
      it.screen_pressed    = 1'($urandom_range(1));
      it.page_up_pressed   = 1'($urandom_range(1));
      it.page_down_pressed = 1'($urandom_range(1));
    end
    return it;
  endfunction

  // Offers one beat, after a random hold-off, and returns at the edge where
  // it is accepted. Valid is left high so back-to-back beats need no gap.
  task send_beat(bped_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.kind              <= it.kind;
    in_ch.time_ms           <= it.time_ms;
    in_ch.screen_pressed    <= it.screen_pressed;
    in_ch.page_up_pressed   <= it.page_up_pressed;
    in_ch.page_down_pressed <= it.page_down_pressed;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Holds the sender back until every predicted result has come out, then
  // lets the pipeline settle so the block is idle.
  task wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both thresholds, one after the other, only while idle.
  task write_thresholds(logic [CfgW-1:0] debounce, logic [CfgW-1:0] long_press);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DEBOUNCE;
    cfg_data <= debounce;
    @(posedge clk);
    cfg_idx  <= CFG_LONG_PRESS;
    cfg_data <= long_press;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.set_reg(CFG_DEBOUNCE, debounce);
    sb.set_reg(CFG_LONG_PRESS, long_press);
  endtask

  initial begin
    logic [CfgW-1:0] deb_set[NUM_PHASES];
    logic [CfgW-1:0] long_set[NUM_PHASES];
    int phase;
    int n;

    in_ch.valid             = 1'b0;
    in_ch.kind              = 1'b0;
    in_ch.time_ms           = '0;
    in_ch.screen_pressed    = 1'b0;
    in_ch.page_up_pressed   = 1'b0;
    in_ch.page_down_pressed = 1'b0;
    out_ch.ready            = 1'b0;
    cfg_we                  = 1'b0;
    cfg_idx                 = '0;
    cfg_data                = '0;
    rst_n                   = 1'b0;
    quiet_cycles            = 0;
    now_ms                  = 32'hFFFF_F000;
    lvl_scr                 = 1'b0;
    lvl_up                  = 1'b0;
    lvl_dn                  = 1'b0;
    send_idle_pct           = 19;
    recv_idle_pct           = 77;

    // Threshold settings of the random phases, zero and full scale among them.
    deb_set  = '{16'd0, 16'hFFFF, 16'd10, 16'd40, 16'd1, 16'd50};
    long_set = '{16'd0, 16'hFFFF, 16'd40, 16'd8,  16'd1, 16'd300};

    // Directed sequence, run at the reset thresholds (50 ms debounce, 300 ms
    // long press). Each line notes the behavior it is aimed at.
    // A take with nothing pending returns no event.
    directed_q.push_back(make_item(1'b1, 32'd0, 1'b0, 1'b0, 1'b0));
    // A toggle press inside the debounce window is dropped and stays released.
    directed_q.push_back(make_item(1'b0, 32'd10, 1'b1, 1'b0, 1'b0));
    // The same press retried exactly at the window edge fires.
    directed_q.push_back(make_item(1'b0, 32'd50, 1'b1, 1'b0, 1'b0));
    // A sample while an event waits is ignored entirely.
    directed_q.push_back(make_item(1'b0, 32'd60, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(make_item(1'b1, 32'd61, 1'b0, 1'b0, 1'b0));
    // Page up pressed, held one short of the long time, then exactly at it.
    directed_q.push_back(make_item(1'b0, 32'd70, 1'b1, 1'b1, 1'b0));
    directed_q.push_back(make_item(1'b0, 32'd369, 1'b1, 1'b1, 1'b0));
    directed_q.push_back(make_item(1'b0, 32'd370, 1'b1, 1'b1, 1'b0));
    directed_q.push_back(make_item(1'b1, 32'd371, 1'b1, 1'b1, 1'b0));
    // Release after a long event gives nothing and processing moves on to
    // page down, which is pressed here and then released for a short event.
    directed_q.push_back(make_item(1'b0, 32'd400, 1'b0, 1'b0, 1'b1));
    directed_q.push_back(make_item(1'b0, 32'd450, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(make_item(1'b1, 32'd451, 1'b0, 1'b0, 1'b0));
    // Both page buttons held: up wins first, down fires its long event after.
    directed_q.push_back(make_item(1'b0, 32'd460, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(make_item(1'b0, 32'd760, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(make_item(1'b1, 32'd760, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(make_item(1'b0, 32'd761, 1'b0, 1'b1, 1'b1));
    directed_q.push_back(make_item(1'b1, 32'd762, 1'b0, 1'b0, 1'b0));
    // A toggle press still inside the debounce window is dropped, and the page releases are recorded.
    directed_q.push_back(make_item(1'b0, 32'd800, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(make_item(1'b1, 32'd800, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(make_item(1'b0, 32'd801, 1'b1, 1'b0, 1'b0));
    // Debounce across the wrap of the millisecond counter.
    directed_q.push_back(make_item(1'b0, 32'hFFFF_FFF0, 1'b0, 1'b0, 1'b0));
    directed_q.push_back(make_item(1'b0, 32'h0000_0020, 1'b1, 1'b0, 1'b0));
    directed_q.push_back(make_item(1'b0, 32'h0000_0022, 1'b1, 1'b0, 1'b0));
    // Take beat with every ignored field at its top value.
    directed_q.push_back(make_item(1'b1, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));
    // Page presses at the top of the time range.
    directed_q.push_back(make_item(1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_q[i]) send_beat(directed_q[i]);

    // Random phases. The first two stall mostly on the receiver, the next
    // two mostly on the sender, the last two not at all. Before every phase
    // the sender pauses until all results are out, then the thresholds change.
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      if (phase == 2) begin
        send_idle_pct = 77;
        recv_idle_pct = 19;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_thresholds(deb_set[phase], long_set[phase]);
      for (n = 0; n < ITEMS_PER_PHASE; n++) send_beat(next_random_item());
    end

    wait_drained();
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d result beats never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("button_press_event_detector_core_test passed");
    end else begin
      $display("button_press_event_detector_core_test failed");
    end
    $finish;
  end

endmodule
